### src/seqglt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seqglt_pkg
// Shared types, codes and constants of the sequence gap and loss tracker.
// ----------------------------------------------------------------------------
package seqglt_pkg;

    localparam int NUM_NODES = 16;
    localparam int IDX_W     = $clog2(NUM_NODES);

    localparam logic [2:0] CMD_MESH   = 3'd0;
    localparam logic [2:0] CMD_LEGACY = 3'd1;
    localparam logic [2:0] CMD_SWEEP  = 3'd2;
    localparam logic [2:0] CMD_QUERY  = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [2:0] ST_NO_DATA = 3'd0;
    localparam logic [2:0] ST_ONLINE  = 3'd1;
    localparam logic [2:0] ST_OFFLINE = 3'd2;
    localparam logic [2:0] ST_SELF    = 3'd3;
    localparam logic [2:0] ST_INVALID = 3'd4;

    localparam logic [8:0]  MESH_LIMIT   = 9'd100;
    localparam logic [16:0] LEGACY_LIMIT = 17'd1000;
    localparam logic [3:0]  ALERT_MAX    = 4'd15;
    localparam logic [22:0] AGE_RECIP    = 23'd4294967; // floor(2^32 / 1000)
    localparam logic [31:0] MS_PER_S     = 32'd1000;
    localparam logic [31:0] TIMEOUT_RST  = 32'd60000;
    localparam logic [5:0]  OWN_ID_RST   = 6'd1;

    typedef struct packed {
        logic        has_data;
        logic        online;
        logic [15:0] prev_seq;
        logic [15:0] expected_seq;
        logic [31:0] heard_time;
        logic [31:0] msg_total;
        logic [31:0] lost_total;
    } t_entry;

    typedef struct packed {
        logic [7:0]  node;
        logic [2:0]  status;
        logic [15:0] gap;
        logic [31:0] lost;
        logic [31:0] rcv;
        logic [31:0] diff;
        logic [22:0] q0;
        logic [5:0]  heard;
        logic        alert;
        logic        last;
    } t_res;

endpackage

### src/seq_gap_loss_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seq_gap_loss_tracker_core
// Per-node packet sequence gap, loss and timeout tracker.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) carries one command item: mesh or
//   legacy packet, timeout sweep, status query or clear. Result channel
//   (o_valid / i_ready) returns items; o_last marks the final one of a
//   command. A sweep returns one offline alert per timed-out node (at most
//   15) and then a summary item; every other command returns one item;
//   unused command codes return nothing.
//   The node table lives in a ring of NUM_NODES cells. Every command turns
//   the ring once, one entry per cycle through the head cell unless an
//   alert waits for a free slot in the full result queue. A command is
//   taken, the ring steps once per cell, the final item is queued, and
//   only then is the next command taken. An alert passes through the
//   queue's result slot and output register on its way to the port.
//   Reset (synchronous) empties the table, drops queued results and loads
//   timeout_ms = 60000 and own_node_id = 1. A stalled receiver holds the
//   ring and the input side; nothing is lost.
//   Registers over APB: 0x0 timeout_ms, 0x4 own_node_id.
// ----------------------------------------------------------------------------
module seq_gap_loss_tracker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [7:0]  i_node_id,
    input  logic [15:0] i_seq_number,
    input  logic [31:0] i_now_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_report_node,
    output logic [2:0]  o_status,
    output logic [15:0] o_gap,
    output logic [31:0] o_lost_count,
    output logic [31:0] o_received_count,
    output logic [22:0] o_age_seconds,
    output logic [5:0]  o_nodes_heard,
    output logic        o_offline_alert,
    output logic        o_last
);
    import seqglt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_FINAL} t_state;

    t_state              r_state;
    logic [IDX_W-1:0]    r_pos;
    logic [3:0]          r_alerts;
    logic [5:0]          r_heard;
    logic [2:0]          r_cmd;
    logic [7:0]          r_node;
    logic [15:0]         r_seq;
    logic [31:0]         r_now;
    t_res                r_fin;
    logic [31:0]         r_timeout;
    logic [5:0]          r_own;

    t_entry              ring [NUM_NODES];
    t_entry              proc_entry;
    t_res                proc_res;
    t_res                push_res;
    logic                proc_emit, proc_match, proc_heard_inc;
    logic                push, push_ready, shift, cfg_wr;

    // Configuration port: no wait states; write on the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {26'd0, r_own} : r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
            r_own     <= OWN_ID_RST;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_own <= pwdata[5:0];
            end else begin
                r_timeout <= pwdata;
            end
        end
    end

    // Ring of entry cells; cell 0 takes the updated head entry back.
    for (genvar k = 0; k < NUM_NODES; k++) begin : g_ring
        seqglt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_entry ((k == 0) ? proc_entry : ring[(k == 0) ? 0 : k - 1]),
            .o_entry (ring[k])
        );
    end

    seqglt_proc u_proc (
        .i_entry     (ring[NUM_NODES-1]),
        .i_pos       (r_pos),
        .i_cmd       (r_cmd),
        .i_node      (r_node),
        .i_seq       (r_seq),
        .i_now       (r_now),
        .i_timeout   (r_timeout),
        .i_own       (r_own),
        .i_alerts    (r_alerts),
        .o_entry     (proc_entry),
        .o_emit      (proc_emit),
        .o_match     (proc_match),
        .o_heard_inc (proc_heard_inc),
        .o_res       (proc_res)
    );

    // Hold the ring while an alert waits for a free queue slot.
    assign shift = (r_state == S_RUN) && (!proc_emit || push_ready);
    assign push  = ((r_state == S_RUN) && proc_emit && push_ready)
                || ((r_state == S_FINAL) && push_ready);

    always_comb begin
        if (r_state == S_FINAL) begin
            push_res       = r_fin;
            push_res.heard = r_heard;
            push_res.last  = 1'b1;
        end else begin
            push_res       = proc_res;
            push_res.heard = r_heard;
        end
    end

    seqglt_out u_out (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_res            (push_res),
        .o_push_ready     (push_ready),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_report_node    (o_report_node),
        .o_status         (o_status),
        .o_gap            (o_gap),
        .o_lost_count     (o_lost_count),
        .o_received_count (o_received_count),
        .o_age_seconds    (o_age_seconds),
        .o_nodes_heard    (o_nodes_heard),
        .o_offline_alert  (o_offline_alert),
        .o_last           (o_last)
    );

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_alerts <= '0;
            r_heard  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && i_command <= CMD_CLEAR) begin
                        r_state  <= S_RUN;
                        r_pos    <= '0;
                        r_alerts <= '0;
                        if (i_command == CMD_CLEAR) begin
                            r_heard <= '0;
                        end
                    end
                end
                S_RUN: begin
                    if (shift) begin
                        if (proc_heard_inc) begin
                            r_heard <= r_heard + 6'd1;
                        end
                        if (r_pos == IDX_W'(NUM_NODES - 1)) begin
                            r_state <= S_FINAL;
                            r_pos   <= '0;
                        end else begin
                            r_pos <= r_pos + 1'b1;
                        end
                    end
                    if (push) begin
                        r_alerts <= r_alerts + 4'd1;
                    end
                end
                S_FINAL: begin
                    if (push_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        // Command payload and final result: no reset needed.
        if (r_state == S_IDLE && i_valid) begin
            r_cmd  <= i_command;
            r_node <= i_node_id;
            r_seq  <= i_seq_number;
            r_now  <= i_now_ms;
            if (i_command == CMD_MESH || i_command == CMD_LEGACY) begin
                r_fin <= '{node: i_node_id, status: ST_INVALID, default: '0};
            end else if (i_command == CMD_QUERY) begin
                r_fin <= '{node: i_node_id,
                           status: (i_node_id == {2'b00, r_own} && i_node_id != 8'd0)
                                   ? ST_SELF : ST_INVALID,
                           default: '0};
            end else begin
                r_fin <= '0;
            end
        end else if (r_state == S_RUN && shift && proc_match) begin
            r_fin <= proc_res;
        end
    end

endmodule

### src/seqglt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seqglt_cell
// One ring cell: holds a node entry and hands it on when the ring advances.
// ----------------------------------------------------------------------------
module seqglt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  seqglt_pkg::t_entry  i_entry,
    output seqglt_pkg::t_entry  o_entry
);
    import seqglt_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= '0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

### src/seqglt_proc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seqglt_proc
// Head cell logic: update the entry leaving the ring and form any result.
// ----------------------------------------------------------------------------
module seqglt_proc (
    input  seqglt_pkg::t_entry  i_entry,
    input  logic [seqglt_pkg::IDX_W-1:0] i_pos,
    input  logic [2:0]          i_cmd,
    input  logic [7:0]          i_node,
    input  logic [15:0]         i_seq,
    input  logic [31:0]         i_now,
    input  logic [31:0]         i_timeout,
    input  logic [5:0]          i_own,
    input  logic [3:0]          i_alerts,
    output seqglt_pkg::t_entry  o_entry,
    output logic                o_emit,
    output logic                o_match,
    output logic                o_heard_inc,
    output seqglt_pkg::t_res    o_res
);
    import seqglt_pkg::*;

    logic [7:0]  node_id;
    logic [31:0] diff;
    logic [54:0] prod;
    logic [7:0]  m, e8, p8;
    logic [8:0]  gap9;
    logic [16:0] gap17;
    logic [15:0] gap;
    logic [15:0] new_seq;
    logic [32:0] lost_sum;
    logic [31:0] lost_new, msg_new;
    logic        is_pkt, is_self, timed_out;

    always_comb begin
        node_id   = 8'(i_pos) + 8'd1;
        diff      = i_now - i_entry.heard_time;
        prod      = 55'(diff) * 55'(AGE_RECIP);
        is_pkt    = (i_cmd == CMD_MESH) || (i_cmd == CMD_LEGACY);
        is_self   = (node_id == {2'b00, i_own});
        timed_out = diff > i_timeout;

        m     = i_seq[7:0];
        e8    = i_entry.expected_seq[7:0];
        p8    = i_entry.prev_seq[7:0];
        gap9  = '0;
        gap17 = '0;
        gap   = '0;
        if (i_cmd == CMD_MESH) begin
            new_seq = {8'd0, m};
            if (i_entry.has_data && m != e8) begin
                if (m > e8) begin
                    gap9 = {1'b0, m} - {1'b0, e8};
                end else if (m < p8) begin
                    gap9 = 9'd256 - {1'b0, e8} + {1'b0, m};
                end
            end
            gap = 16'(gap9);
            lost_sum = 33'(i_entry.lost_total) + 33'(gap);
            lost_new = (gap9 != '0 && gap9 < MESH_LIMIT)
                     ? (lost_sum[32] ? '1 : lost_sum[31:0]) : i_entry.lost_total;
        end else begin
            new_seq = i_seq;
            if (i_entry.has_data && i_seq != i_entry.expected_seq) begin
                if (i_seq > i_entry.expected_seq) begin
                    gap17 = {1'b0, i_seq} - {1'b0, i_entry.expected_seq};
                end else if (i_seq < i_entry.prev_seq) begin
                    gap17 = 17'h10000 - {1'b0, i_entry.expected_seq} + {1'b0, i_seq};
                end
            end
            gap = gap17[15:0];
            lost_sum = 33'(i_entry.lost_total) + 33'(gap);
            lost_new = (gap != '0 && {1'b0, gap} < LEGACY_LIMIT)
                     ? (lost_sum[32] ? '1 : lost_sum[31:0]) : i_entry.lost_total;
        end
        msg_new = (&i_entry.msg_total) ? i_entry.msg_total : i_entry.msg_total + 32'd1;

        o_entry     = i_entry;
        o_emit      = 1'b0;
        o_match     = 1'b0;
        o_heard_inc = 1'b0;
        o_res       = '0;
        o_res.node  = node_id;
        o_res.lost  = i_entry.lost_total;
        o_res.rcv   = i_entry.msg_total;
        o_res.last  = 1'b1;
        if (i_entry.has_data) begin
            o_res.diff = diff;
            o_res.q0   = prod[54:32];
        end

        unique case (i_cmd)
            CMD_MESH, CMD_LEGACY: begin
                if (i_node == node_id) begin
                    o_match               = 1'b1;
                    o_heard_inc           = !i_entry.has_data;
                    o_entry.has_data      = 1'b1;
                    o_entry.online        = 1'b1;
                    o_entry.prev_seq      = new_seq;
                    o_entry.expected_seq  = new_seq + 16'd1;
                    o_entry.heard_time    = i_now;
                    o_entry.msg_total     = msg_new;
                    o_entry.lost_total    = lost_new;
                    o_res.status          = is_self ? ST_SELF : ST_ONLINE;
                    o_res.gap             = gap;
                    o_res.lost            = lost_new;
                    o_res.rcv             = msg_new;
                    o_res.diff            = '0;
                    o_res.q0              = '0;
                end
            end
            CMD_QUERY: begin
                if (i_node == node_id) begin
                    o_match = 1'b1;
                    if (is_self) begin
                        o_res.status = ST_SELF;
                    end else if (!i_entry.has_data) begin
                        o_res.status = ST_NO_DATA;
                    end else begin
                        o_res.status = i_entry.online ? ST_ONLINE : ST_OFFLINE;
                    end
                end
            end
            CMD_SWEEP: begin
                if (!is_self && i_entry.has_data && i_entry.online && timed_out
                    && i_alerts < ALERT_MAX) begin
                    o_emit         = 1'b1;
                    o_entry.online = 1'b0;
                    o_res.status   = ST_OFFLINE;
                    o_res.alert    = 1'b1;
                    o_res.last     = 1'b0;
                end
            end
            CMD_CLEAR: begin
                o_entry = '0;
            end
            default: begin
            end
        endcase
        if (is_pkt && !o_match) begin
            o_res.status = ST_NO_DATA;
        end
    end

endmodule

### src/seqglt_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seqglt_out
// Two-slot result queue; finishes the age division on the way to the port.
// ----------------------------------------------------------------------------
module seqglt_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  seqglt_pkg::t_res   i_res,
    output logic               o_push_ready,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_report_node,
    output logic [2:0]         o_status,
    output logic [15:0]        o_gap,
    output logic [31:0]        o_lost_count,
    output logic [31:0]        o_received_count,
    output logic [22:0]        o_age_seconds,
    output logic [5:0]         o_nodes_heard,
    output logic               o_offline_alert,
    output logic               o_last
);
    import seqglt_pkg::*;

    t_res        r_res;
    logic        r_res_valid;
    logic        r_out_valid;
    logic        move;
    logic [31:0] rem;
    logic [22:0] age;

    assign move         = r_res_valid && (!r_out_valid || i_ready);
    assign o_push_ready = !r_res_valid || move;
    assign rem          = r_res.diff - 32'(r_res.q0) * MS_PER_S;
    assign age          = (rem >= MS_PER_S) ? r_res.q0 + 23'd1 : r_res.q0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_push) begin
                r_res_valid <= 1'b1;
            end else if (move) begin
                r_res_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_push) begin
            r_res <= i_res;
        end
        if (move) begin
            o_report_node    <= r_res.node;
            o_status         <= r_res.status;
            o_gap            <= r_res.gap;
            o_lost_count     <= r_res.lost;
            o_received_count <= r_res.rcv;
            o_age_seconds    <= age;
            o_nodes_heard    <= r_res.heard;
            o_offline_alert  <= r_res.alert;
            o_last           <= r_res.last;
        end
    end

    assign o_valid = r_out_valid;

endmodule
